[design/shader_source_minifier_defines.svh]
// Assertion macros used by the checker file of the minifier.
`ifndef SHADER_SOURCE_MINIFIER_DEFINES_SVH
`define SHADER_SOURCE_MINIFIER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SMIN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SMIN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/smin_pkg.sv]
`timescale 1ns / 1ps

package smin_pkg;

	// Character codes the scanner looks at.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Most bytes one input item can produce.
	localparam int MAX_OUT = 5;
	localparam int CNT_W   = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
	} out_item_t;

	typedef enum logic [3:0] {
		MODE_NORMAL    = 4'b0001,
		MODE_LINE      = 4'b0010,
		MODE_BLOCK     = 4'b0100,
		MODE_DIRECTIVE = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t mode;
		logic       skip;
		logic [7:0] prev_char;
		logic       prev_valid;
	} scan_st_t;

	localparam scan_st_t SCAN_RESET = '{mode: MODE_NORMAL, skip: 1'b0,
		prev_char: 8'h00, prev_valid: 1'b0};

	// Outcome of judging one character: new state and up to three bytes.
	typedef struct packed {
		scan_st_t        st;
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
	} judge_res_t;

	// Bytes for the output serialiser, produced from one input item.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    stream_end;
	} burst_t;

	function automatic logic is_alnum(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == CH_TAB || c == CH_CR || c == CH_FF || c == CH_LF;
	endfunction

	// Append one character; CR is dropped and LF goes out as backslash, n.
	function automatic judge_res_t emit_char(judge_res_t r_in, logic [7:0] c);
		judge_res_t r;
		r = r_in;
		if (c != CH_CR) begin
			r.st.prev_char  = c;
			r.st.prev_valid = 1'b1;
			if (c == CH_LF) begin
				r.bytes[r.cnt[1:0]]         = CH_BSL;
				r.bytes[r.cnt[1:0] + 2'd1]  = CH_N;
				r.cnt                       = r.cnt + 3'd2;
			end else begin
				r.bytes[r.cnt[1:0]] = c;
				r.cnt               = r.cnt + 3'd1;
			end
		end
		return r;
	endfunction

	// Judge character c with one byte of lookahead.
	function automatic judge_res_t judge(scan_st_t st, logic [7:0] c, logic [7:0] nxt);
		judge_res_t r;
		r.st    = st;
		r.bytes = '0;
		r.cnt   = '0;
		if (st.skip) begin
			r.st.skip = 1'b0;
		end else begin
			unique case (st.mode)
				MODE_LINE: begin
					if (c == CH_LF) r.st.mode = MODE_NORMAL;
				end
				MODE_BLOCK: begin
					if (c == CH_STAR && nxt == CH_SLASH) begin
						r.st.mode = MODE_NORMAL;
						r.st.skip = 1'b1;
					end
				end
				MODE_DIRECTIVE: begin
					r = emit_char(r, c);
					if (c == CH_LF) r.st.mode = MODE_NORMAL;
				end
				MODE_NORMAL: begin
					priority if (c == CH_SPACE && !(st.prev_valid && is_alnum(st.prev_char)
						&& is_alnum(nxt))) begin
						r = r;
					end else if (is_ws(c)) begin
						r = r;
					end else if (c == CH_HASH) begin
						if (st.prev_valid && st.prev_char != CH_LF) r = emit_char(r, CH_LF);
						r = emit_char(r, c);
						r.st.mode = MODE_DIRECTIVE;
					end else if (c == CH_SLASH && nxt == CH_SLASH) begin
						r.st.mode = MODE_LINE;
					end else if (c == CH_SLASH && nxt == CH_STAR) begin
						r.st.mode = MODE_BLOCK;
					end else begin
						r = emit_char(r, c);
					end
				end
				default: begin
					r = r;
				end
			endcase
		end
		return r;
	endfunction

endpackage

[design/smin_front.sv]
`timescale 1ns / 1ps

module smin_front import smin_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     text_valid,
	output logic     text_stall,
	input  in_item_t text_item,
	output logic     burst_valid,
	input  logic     burst_take,
	output burst_t   burst
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	scan_st_t   state_q;
	logic [7:0] held_q;
	logic       held_valid_q;
	logic       consume;
	judge_res_t r1;
	judge_res_t r2;
	logic [3:0] sum;

	assign burst_valid = valid_s1;
	assign consume     = valid_s1 && burst_take;
	assign text_stall  = valid_s1 && !burst_take;

	// Input register: refilled whenever its item moves on or it is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall) begin
			byte_s1 <= text_item.in_byte;
			last_s1 <= text_item.in_last;
		end
	end

	// Judge the held byte against the new one, then flush on the final item.
	always_comb begin
		r1.st    = state_q;
		r1.bytes = '0;
		r1.cnt   = '0;
		if (held_valid_q) r1 = judge(state_q, held_q, byte_s1);
		r2.st    = r1.st;
		r2.bytes = '0;
		r2.cnt   = '0;
		if (last_s1) r2 = judge(r1.st, byte_s1, CH_NUL);
	end

	// Pack both results into one burst, at most five bytes.
	always_comb begin
		logic [3:0] off;
		for (int k = 0; k < MAX_OUT; k++) begin
			off = 4'(k) - {1'b0, r1.cnt};
			if (4'(k) < {1'b0, r1.cnt}) begin
				burst.bytes[k] = r1.bytes[off[1:0] + 2'(k) - off[1:0]];
			end else begin
				burst.bytes[k] = r2.bytes[off[1:0]];
			end
		end
		sum              = {1'b0, r1.cnt} + {1'b0, r2.cnt};
		burst.cnt        = (sum > 4'(MAX_OUT)) ? CNT_W'(MAX_OUT) : sum[CNT_W-1:0];
		burst.stream_end = last_s1;
	end

	// Scanner state advances as the item is handed on; the final item resets it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SCAN_RESET;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				state_q      <= SCAN_RESET;
				held_q       <= 8'h00;
				held_valid_q <= 1'b0;
			end else begin
				state_q      <= r2.st;
				held_q       <= byte_s1;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule

[design/smin_serial.sv]
`timescale 1ns / 1ps

module smin_serial import smin_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      burst_valid,
	output logic      burst_take,
	input  burst_t    burst,
	output logic      mini_valid,
	input  logic      mini_stall,
	output out_item_t mini_item
);

	logic [MAX_OUT-1:0][7:0] bytes_s2;
	logic [CNT_W-1:0]        cnt_s2;
	logic                    end_s2;
	logic                    out_acc;
	logic                    load;

	assign mini_valid           = cnt_s2 != '0;
	assign out_acc              = mini_valid && !mini_stall;
	assign burst_take           = (cnt_s2 == '0) ||
		(cnt_s2 == CNT_W'(1) && out_acc);
	assign load                 = burst_valid && burst_take;
	assign mini_item.out_byte   = bytes_s2[0];
	assign mini_item.run_last   = cnt_s2 == CNT_W'(1);
	assign mini_item.stream_end = end_s2;

	// Count of bytes still to send.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= burst.cnt;
		end else if (out_acc) begin
			cnt_s2 <= cnt_s2 - CNT_W'(1);
		end
	end

	// Burst bytes shift down one place per delivered item.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= burst.bytes;
			end_s2   <= burst.stream_end;
		end else if (out_acc) begin
			bytes_s2 <= {8'h00, bytes_s2[MAX_OUT-1:1]};
		end
	end

endmodule

[design/shader_source_minifier.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// text      in   text_valid/text_stall   in_item_t  (in_byte, in_last)
// mini      out  mini_valid/mini_stall   out_item_t (out_byte, run_last, stream_end)
//
// One input item is taken per cycle while each item yields at most one byte and the output is not stalled.
// An item that yields n bytes holds the output shift register until all n bytes are delivered.
// The first result passes the input register, then the output shift register, before it shows.
// Reset clears the scanner state and both valid flags; no clearing pass.
// A stalled output holds its item; the input stalls only when the burst is busy.

module shader_source_minifier import smin_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      text_valid,
	output logic      text_stall,
	input  in_item_t  text_item,
	output logic      mini_valid,
	input  logic      mini_stall,
	output out_item_t mini_item
);

	logic   burst_valid;
	logic   burst_take;
	burst_t burst;

	smin_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_item   (text_item),
		.burst_valid (burst_valid),
		.burst_take  (burst_take),
		.burst       (burst)
	);

	smin_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst_take  (burst_take),
		.burst       (burst),
		.mini_valid  (mini_valid),
		.mini_stall  (mini_stall),
		.mini_item   (mini_item)
	);

endmodule

[design/smin_checker.sv]
`timescale 1ns / 1ps
`include "shader_source_minifier_defines.svh"

module smin_checker import smin_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      text_valid,
	input logic      text_stall,
	input in_item_t  text_item,
	input logic      mini_valid,
	input logic      mini_stall,
	input out_item_t mini_item
);

	// A stalled source item holds.
	`SMIN_ASSERT_NXT(a_in_hold, text_valid && text_stall, text_valid && $stable(text_item), "source item changed while stalled")

	// A stalled result item holds.
	`SMIN_ASSERT_NXT(a_out_hold, mini_valid && mini_stall, mini_valid && $stable(mini_item), "result item changed while stalled")

	// With the output empty the input is never stalled.
	`SMIN_ASSERT_IMP(a_no_idle_stall, !mini_valid, !text_stall, "input stalled with empty output")

	// A burst continues after a non-final byte, with the same stream end flag.
	`SMIN_ASSERT_NXT(a_burst_cont, mini_valid && !mini_stall && !mini_item.run_last, mini_valid && (mini_item.stream_end == $past(mini_item.stream_end)), "burst broken before its last byte")

endmodule

bind shader_source_minifier smin_checker u_smin_checker (.*);

[sim/shader_source_minifier_test.sv]
`timescale 1ns / 1ps

module shader_source_minifier_test import smin_pkg::*; ;

	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 60000;

	// Expected minified bytes, worked out from every accepted source item.
	class minified_text_board;
		out_item_t  expected_q[$];
		int         errors;
		scan_mode_t mode;
		logic [7:0] held;
		logic       held_ok;
		logic       skip;
		logic [7:0] last_char;
		logic       last_ok;
		logic [7:0] burst[$];

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			mode      = MODE_NORMAL;
			held      = 8'h00;
			held_ok   = 1'b0;
			skip      = 1'b0;
			last_char = 8'h00;
			last_ok   = 1'b0;
		endfunction

		function bit alnum(logic [7:0] c);
			return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h61 && c <= 8'h7A);
		endfunction

		// Emit one character: CR vanishes, LF becomes backslash and n.
		function void put_char(logic [7:0] c);
			if (c != CH_CR) begin
				last_char = c;
				last_ok   = 1'b1;
				if (c == CH_LF) begin
					burst.push_back(CH_BSL);
					burst.push_back(CH_N);
				end else begin
					burst.push_back(c);
				end
			end
		endfunction

		// Decide what one character becomes, given the byte that follows it.
		function void scan(logic [7:0] c, logic [7:0] nxt);
			if (skip) begin
				skip = 1'b0;
			end else if (mode == MODE_LINE) begin
				if (c == CH_LF) mode = MODE_NORMAL;
			end else if (mode == MODE_BLOCK) begin
				if (c == CH_STAR && nxt == CH_SLASH) begin
					mode = MODE_NORMAL;
					skip = 1'b1;
				end
			end else if (mode == MODE_DIRECTIVE) begin
				put_char(c);
				if (c == CH_LF) mode = MODE_NORMAL;
			end else if (c == CH_SPACE && !(last_ok && alnum(last_char) && alnum(nxt))) begin
				// A space survives only between two alphanumerics.
			end else if (c == CH_TAB || c == CH_CR || c == CH_FF || c == CH_LF) begin
				// Other whitespace is always dropped.
			end else if (c == CH_HASH) begin
				if (last_ok && last_char != CH_LF) put_char(CH_LF);
				put_char(c);
				mode = MODE_DIRECTIVE;
			end else if (c == CH_SLASH && nxt == CH_SLASH) begin
				mode = MODE_LINE;
			end else if (c == CH_SLASH && nxt == CH_STAR) begin
				mode = MODE_BLOCK;
			end else begin
				put_char(c);
			end
		endfunction

		// Judge the held byte against the new one, and flush on the final item.
		function void note_input(in_item_t it);
			int        n;
			out_item_t e;
			burst.delete();
			if (held_ok) scan(held, it.in_byte);
			held    = it.in_byte;
			held_ok = 1'b1;
			if (it.in_last) scan(it.in_byte, CH_NUL);
			n = (burst.size() > MAX_OUT) ? MAX_OUT : burst.size();
			for (int k = 0; k < n; k++) begin
				e.out_byte   = burst[k];
				e.run_last   = (k == n - 1);
				e.stream_end = it.in_last;
				expected_q.push_back(e);
			end
			if (it.in_last) clear();
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result item: out_byte %h", got.out_byte);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, actual %b", want.run_last, got.run_last);
				errors++;
			end
			if (got.stream_end !== want.stream_end) begin
				$error("stream_end: expected %b, actual %b", want.stream_end, got.stream_end);
				errors++;
			end
		endfunction
	endclass

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      text_valid = 1'b0;
	logic      text_stall;
	in_item_t  text_item  = '0;
	logic      mini_valid;
	logic      mini_stall = 1'b0;
	out_item_t mini_item;

	minified_text_board board = new();

	int sent    = 0;
	bit quiet   = 1'b0;
	bit hold_go = 1'b0;
	int cycles  = 0;

	shader_source_minifier i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item),
		.mini_valid (mini_valid),
		.mini_stall (mini_stall),
		.mini_item  (mini_item)
	);

	always #6 clk = ~clk;

	// Both handshakes are observed on the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall) board.note_input(text_item);
			if (mini_valid && !mini_stall) board.check_result(mini_item);
		end
	end

	// Receiver: random stalls, one long hold-off, and a calm stretch.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				mini_stall <= 1'b1;
				hold_left--;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				mini_stall <= 1'b1;
			end else begin
				mini_stall <= !quiet && ($urandom_range(99) < 12);
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("shader_source_minifier_test: done, errors");
		$finish;
	end

	function automatic logic [7:0] alnum_byte();
		case ($urandom_range(0, 2))
			0:       return 8'(8'h30 + $urandom_range(0, 9));
			1:       return 8'(8'h41 + $urandom_range(0, 25));
			default: return 8'(8'h61 + $urandom_range(0, 25));
		endcase
	endfunction

	// Comment and directive bodies: alphanumerics, spaces, stars, slashes, CR and noise.
	function automatic logic [7:0] filler_byte();
		case ($urandom_range(0, 5))
			0:       return alnum_byte();
			1:       return CH_SPACE;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			4:       return CH_CR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// A source text built from mostly well-formed pieces with random content.
	function automatic void build_text(ref logic [7:0] txt[$]);
		txt.delete();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 7))
				0: repeat ($urandom_range(1, 4)) txt.push_back(alnum_byte());
				1: repeat ($urandom_range(1, 2)) txt.push_back(CH_SPACE);
				2: begin
					txt.push_back(CH_SLASH);
					txt.push_back(CH_SLASH);
					repeat ($urandom_range(0, 3)) txt.push_back(filler_byte());
					txt.push_back(CH_LF);
				end
				3: begin
					txt.push_back(CH_SLASH);
					txt.push_back(CH_STAR);
					repeat ($urandom_range(0, 3)) txt.push_back(filler_byte());
					txt.push_back(CH_STAR);
					txt.push_back(CH_SLASH);
				end
				4: begin
					txt.push_back(CH_HASH);
					repeat ($urandom_range(0, 4)) txt.push_back(filler_byte());
					if ($urandom_range(0, 1)) txt.push_back(CH_CR);
					txt.push_back(CH_LF);
				end
				5: begin
					case ($urandom_range(0, 3))
						0:       txt.push_back(CH_TAB);
						1:       txt.push_back(CH_CR);
						2:       txt.push_back(CH_FF);
						default: txt.push_back(CH_LF);
					endcase
				end
				6: txt.push_back(8'($urandom_range(8'h21, 8'h2F)));
				default: txt.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	// Offer one item from a falling edge and wait until it is taken.
	task automatic send_item(input logic [7:0] b, input logic l);
		while (!quiet && $urandom_range(99) < 12) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_item  <= '{in_byte: b, in_last: l};
		do @(posedge clk); while (text_stall);
		sent++;
		if (sent == 60) hold_go = 1'b1;
		quiet = (sent >= 100 && sent < 160);
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] txt[$]);
		for (int k = 0; k < txt.size(); k++) send_item(txt[k], k == txt.size() - 1);
	endtask

	initial begin
		logic [7:0] txt[$];
		int         random_end;
		bit         paused;
		paused = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Space between two alphanumerics is kept.
		txt = '{8'h61, CH_SPACE, 8'h62};
		send_text(txt);
		// Slash, star, slash already closes a block comment.
		txt = '{8'h78, CH_SLASH, CH_STAR, CH_SLASH, 8'h79};
		send_text(txt);
		// Directive after text starts a fresh line; the last item yields five bytes.
		txt = '{8'h61, CH_HASH, CH_LF};
		send_text(txt);
		// Zero and high bytes pass through; a line comment left open at the end.
		txt = '{CH_NUL, 8'hFF, CH_SLASH, CH_SLASH, 8'h71};
		send_text(txt);
		// Directive at the very start, CR removed, no LF added at the end.
		txt = '{CH_HASH, CH_TAB, CH_CR};
		send_text(txt);
		// Block comment left open: the final item yields nothing.
		txt = '{CH_SLASH, CH_STAR};
		send_text(txt);
		// Whitespace dropped; a trailing space sees a zero lookahead.
		txt = '{8'h5A, CH_TAB, CH_FF, CH_LF, CH_SPACE};
		send_text(txt);

		// Random source texts, with one pause until the output has drained.
		random_end = sent + RANDOM_ITEMS;
		while (sent < random_end) begin
			build_text(txt);
			send_text(txt);
			if (!paused && sent >= 180) begin
				paused = 1'b1;
				text_valid <= 1'b0;
				@(negedge clk);
				while (board.expected_q.size() != 0) @(negedge clk);
			end
		end
		text_valid <= 1'b0;

		while (board.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0) begin
			$display("shader_source_minifier_test: done, clean");
		end else begin
			$display("shader_source_minifier_test: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/smin_pkg.sv
design/smin_front.sv
design/smin_serial.sv
design/shader_source_minifier.sv
design/smin_checker.sv
sim/shader_source_minifier_test.sv
